// ===== hdl/ibma_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ibma_pkg
// Shared types, codes and defaults of the id bitmap allocator.
// ----------------------------------------------------------------------------
package ibma_pkg;

  localparam int DEF_NUM_IDS   = 4096;
  localparam int DEF_WORD_BITS = 32;

  localparam int ID_W     = 16;
  localparam int STATUS_W = 2;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 24;

  localparam logic [ID_W-1:0] BASE_ID_RESET = 16'd300;

  typedef enum logic {
    OP_ALLOC   = 1'b0,
    OP_RELEASE = 1'b1
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK       = 2'd0,
    STAT_FULL     = 2'd1,
    STAT_WAS_FREE = 2'd2,
    STAT_RANGE    = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_ALLOC,
    S_REL_IDX,
    S_REL_DIV,
    S_REL_RD,
    S_REL_CHK,
    S_RESP
  } state_t;

  typedef enum logic [2:0] {
    RES_NONE,
    RES_ALLOC,
    RES_FULL,
    RES_RANGE,
    RES_REL
  } res_sel_t;

  typedef struct packed {
    logic     load_in;
    logic     scan_start;
    logic     scan_run;
    logic     clear_run;
    logic     idx_load;
    logic     div_load;
    logic     rel_rd;
    logic     wr_alloc;
    logic     wr_rel;
    res_sel_t res_sel;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic found;
    logic scan_full;
    logic in_range;
    logic bit_set;
  } sts_t;

endpackage
`default_nettype wire

// ===== hdl/ibma_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ibma_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ibma_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 128,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]  wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ===== hdl/ibma_dpath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ibma_dpath
// Datapath: bitmap memory, word scan, id arithmetic and result registers.
// ----------------------------------------------------------------------------
module ibma_dpath #(
  parameter int NUM_IDS   = ibma_pkg::DEF_NUM_IDS,
  parameter int WORD_BITS = ibma_pkg::DEF_WORD_BITS
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire ibma_pkg::cmd_t              cmd,
  output ibma_pkg::sts_t                   sts,
  input  wire logic                        cfg_valid,
  input  wire logic [ibma_pkg::ID_W-1:0]   cfg_data,
  input  wire logic [ibma_pkg::ID_W-1:0]   in_release_id,
  output logic      [ibma_pkg::ID_W-1:0]   out_granted_id,
  output logic      [ibma_pkg::STATUS_W-1:0] out_status
);
  import ibma_pkg::*;

  localparam int MAP_WORDS = (NUM_IDS + WORD_BITS - 1) / WORD_BITS;
  localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int BW        = $clog2(WORD_BITS);
  localparam int LAST      = MAP_WORDS - 1;
  localparam int LAST_BITS = NUM_IDS - LAST * WORD_BITS;
  localparam logic [WORD_BITS-1:0] LAST_MASK = (LAST_BITS == WORD_BITS) ? '1 :
                                               WORD_BITS'((64'd1 << LAST_BITS) - 64'd1);
  localparam logic [AW-1:0] LAST_ADDR = AW'(LAST);
  localparam int DIV_S = ID_W + BW;
  localparam logic [ID_W:0] DIV_M =
    (ID_W+1)'(((64'd1 << DIV_S) + WORD_BITS - 1) / WORD_BITS);
  localparam int PW = 2 * ID_W + 1;

  logic [ID_W-1:0]      base_r;
  logic [ID_W-1:0]      rid_r;
  logic [ID_W-1:0]      idx_r, idx_nxt;
  logic [AW-1:0]        q_r, q_nxt;
  logic [BW-1:0]        bit_r, bit_nxt;
  logic [AW-1:0]        scan_addr_r, scan_addr_nxt;
  logic [ID_W-1:0]      scan_base_r, scan_base_nxt;
  logic [AW-1:0]        chk_addr_r;
  logic [ID_W-1:0]      chk_base_r;
  logic                 chk_vld_r;
  logic [ID_W-1:0]      res_id_r, res_id_nxt;
  status_t              res_st_r, res_st_nxt;
  logic [ID_W-1:0]      out_id_r;
  status_t              out_st_r;

  logic                 wr_en, rd_en;
  logic [AW-1:0]        wr_addr, rd_addr;
  logic [WORD_BITS-1:0] wr_data, rd_data;
  logic [WORD_BITS-1:0] avail, alloc_bit, rel_bit;
  logic [BW-1:0]        ffs;
  logic [PW-1:0]        prod;
  logic [ID_W-1:0]      qw;
  logic [ID_W-1:0]      alloc_id;

  ibma_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (MAP_WORDS),
    .ADDR_W(AW)
  ) u_map (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  // word scan and search
  assign avail = ~rd_data & ((chk_addr_r == LAST_ADDR) ? LAST_MASK : '1);

  always_comb begin
    ffs = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (avail[i]) begin
        ffs = BW'(i);
      end
    end
  end

  assign alloc_bit = WORD_BITS'(1) << ffs;
  assign rel_bit   = WORD_BITS'(1) << bit_r;
  assign alloc_id  = base_r + chk_base_r + ID_W'(ffs);

  // index split by reciprocal multiply
  assign idx_nxt = rid_r - base_r;
  assign prod    = PW'(idx_r) * PW'(DIV_M);
  assign q_nxt   = AW'(prod >> DIV_S);
  assign qw      = ID_W'(q_r) * ID_W'(WORD_BITS);
  assign bit_nxt = BW'(idx_r - qw);

  assign sts.clr_last  = (scan_addr_r == LAST_ADDR);
  assign sts.found     = chk_vld_r && (avail != '0);
  assign sts.scan_full = chk_vld_r && (avail == '0) && (chk_addr_r == LAST_ADDR);
  assign sts.in_range  = ({1'b0, idx_r} < (ID_W+1)'(NUM_IDS));
  assign sts.bit_set   = rd_data[bit_r];

  // memory port selection
  always_comb begin
    wr_en   = cmd.clear_run || cmd.wr_alloc || cmd.wr_rel;
    wr_addr = scan_addr_r;
    wr_data = '0;
    if (cmd.wr_alloc) begin
      wr_addr = chk_addr_r;
      wr_data = rd_data | alloc_bit;
    end else if (cmd.wr_rel) begin
      wr_addr = q_r;
      wr_data = rd_data & ~rel_bit;
    end
    rd_en   = cmd.scan_run || cmd.rel_rd;
    rd_addr = cmd.rel_rd ? q_r : scan_addr_r;
  end

  always_comb begin
    scan_addr_nxt = scan_addr_r;
    scan_base_nxt = scan_base_r;
    if (cmd.scan_start) begin
      scan_addr_nxt = '0;
      scan_base_nxt = '0;
    end else if ((cmd.scan_run || cmd.clear_run) && (scan_addr_r != LAST_ADDR)) begin
      scan_addr_nxt = scan_addr_r + AW'(1);
      scan_base_nxt = scan_base_r + ID_W'(WORD_BITS);
    end
  end

  always_comb begin
    res_id_nxt = res_id_r;
    res_st_nxt = res_st_r;
    case (cmd.res_sel)
      RES_ALLOC: begin
        res_id_nxt = alloc_id;
        res_st_nxt = STAT_OK;
      end
      RES_FULL: begin
        res_id_nxt = '0;
        res_st_nxt = STAT_FULL;
      end
      RES_RANGE: begin
        res_id_nxt = rid_r;
        res_st_nxt = STAT_RANGE;
      end
      RES_REL: begin
        res_id_nxt = rid_r;
        res_st_nxt = sts.bit_set ? STAT_OK : STAT_WAS_FREE;
      end
      default: begin
        res_id_nxt = res_id_r;
        res_st_nxt = res_st_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r      <= BASE_ID_RESET;
      scan_addr_r <= '0;
      scan_base_r <= '0;
      chk_vld_r   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        base_r <= cfg_data;
      end
      scan_addr_r <= scan_addr_nxt;
      scan_base_r <= scan_base_nxt;
      if (cmd.scan_start) begin
        chk_vld_r <= 1'b0;
      end else if (cmd.scan_run) begin
        chk_vld_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      rid_r <= in_release_id;
    end
    if (cmd.idx_load) begin
      idx_r <= idx_nxt;
    end
    if (cmd.div_load) begin
      q_r <= q_nxt;
    end
    if (cmd.rel_rd) begin
      bit_r <= bit_nxt;
    end
    if (cmd.scan_run) begin
      chk_addr_r <= scan_addr_r;
      chk_base_r <= scan_base_r;
    end
    res_id_r <= res_id_nxt;
    res_st_r <= res_st_nxt;
    if (cmd.out_load) begin
      out_id_r <= res_id_r;
      out_st_r <= res_st_r;
    end
  end

  assign out_granted_id = out_id_r;
  assign out_status     = out_st_r;

`ifndef NO_ASSERTIONS
  a_one_writer: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.clear_run, cmd.wr_alloc, cmd.wr_rel}))
    else $error("more than one bitmap write source");

  a_word_in_map: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.rel_rd && sts.in_range) |-> (q_r <= LAST_ADDR))
    else $error("release word index beyond map");

  a_bit_in_word: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.rel_rd && sts.in_range) |=> ({1'b0, bit_r} < (BW+1)'(WORD_BITS)))
    else $error("release bit index beyond word");
`endif

endmodule
`default_nettype wire

// ===== hdl/ibma_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ibma_ctrl
// Controller: clearing pass, request sequencing and output handshake.
// ----------------------------------------------------------------------------
module ibma_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_tvalid,
  input  wire logic           in_opcode,
  output logic                in_tready,
  output logic                out_tvalid,
  input  wire logic           out_tready,
  input  wire ibma_pkg::sts_t sts,
  output ibma_pkg::cmd_t      cmd
);
  import ibma_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;
  logic   out_free;

  assign accept   = in_tvalid && (state_r == S_IDLE);
  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = (opcode_t'(in_opcode) == OP_RELEASE) ? S_REL_IDX : S_ALLOC;
        end
      end
      S_ALLOC: begin
        if (sts.found || sts.scan_full) begin
          state_nxt = S_RESP;
        end
      end
      S_REL_IDX: state_nxt = S_REL_DIV;
      S_REL_DIV: state_nxt = S_REL_RD;
      S_REL_RD: begin
        state_nxt = sts.in_range ? S_REL_CHK : S_RESP;
      end
      S_REL_CHK: state_nxt = S_RESP;
      S_RESP: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_comb begin
    cmd           = '0;
    cmd.res_sel   = RES_NONE;
    in_tready     = 1'b0;
    unique case (state_r)
      S_CLEAR: cmd.clear_run = 1'b1;
      S_IDLE: begin
        in_tready      = 1'b1;
        cmd.load_in    = accept;
        cmd.scan_start = accept;
      end
      S_ALLOC: begin
        cmd.scan_run = 1'b1;
        if (sts.found) begin
          cmd.wr_alloc = 1'b1;
          cmd.res_sel  = RES_ALLOC;
        end else if (sts.scan_full) begin
          cmd.res_sel  = RES_FULL;
        end
      end
      S_REL_IDX: cmd.idx_load = 1'b1;
      S_REL_DIV: cmd.div_load = 1'b1;
      S_REL_RD: begin
        if (sts.in_range) begin
          cmd.rel_rd  = 1'b1;
        end else begin
          cmd.res_sel = RES_RANGE;
        end
      end
      S_REL_CHK: begin
        cmd.res_sel = RES_REL;
        cmd.wr_rel  = sts.bit_set;
      end
      S_RESP: cmd.out_load = out_free;
      default: cmd = '0;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

`ifndef NO_ASSERTIONS
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_tready))
    else $error("output register overwritten while held");

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_tvalid)
    else $error("loaded result not presented");
`endif

endmodule
`default_nettype wire

// ===== hdl/id_bitmap_allocator_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// id_bitmap_allocator_unit
// Bitmap id allocator with a word-serial scan over a RAM-held bitmap.
//
// in_*  : one request per item; in_tuser is the opcode (allocate or release),
//         in_tdata the id to release.
// out_* : one result per request, granted or echoed id and a status code.
// cfg_* : write of base_id, the id given to bitmap index zero; write it only
//         while no request is in flight.
// After reset a clearing pass writes every bitmap word (128 by default),
// one word a cycle; in_tready stays low.
// Allocate: the scan reads one bitmap word a cycle from the single read
// port of the RAM, up to the first word with a free bit or the last word.
// Release: index, divide, read, check and result steps; an id out of range
// skips the check.
// Results sit in an output register; the next request is taken while a
// result waits, and a stalled receiver holds the block in its result step.
// ----------------------------------------------------------------------------
module id_bitmap_allocator_unit #(
  parameter int NUM_IDS   = ibma_pkg::DEF_NUM_IDS,
  parameter int WORD_BITS = ibma_pkg::DEF_WORD_BITS
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  input  wire logic [ibma_pkg::IN_TDATA_W-1:0]    in_tdata,  // release_id
  input  wire logic                               in_tuser,  // opcode
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  output logic      [ibma_pkg::OUT_TDATA_W-1:0]   out_tdata, // granted_id, status
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [ibma_pkg::ID_W-1:0]          cfg_data   // base_id
);
  import ibma_pkg::*;

  cmd_t                cmd;
  sts_t                sts;
  logic [ID_W-1:0]     granted_id;
  logic [STATUS_W-1:0] status;

  assign cfg_ready = 1'b1;

  ibma_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_opcode (in_tuser),
    .in_tready (in_tready),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ibma_dpath #(
    .NUM_IDS  (NUM_IDS),
    .WORD_BITS(WORD_BITS)
  ) u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .cfg_valid     (cfg_valid),
    .cfg_data      (cfg_data),
    .in_release_id (in_tdata[ID_W-1:0]),
    .out_granted_id(granted_id),
    .out_status    (status)
  );

  assign out_tdata = {{(OUT_TDATA_W - ID_W - STATUS_W){1'b0}}, status, granted_id};

endmodule
`default_nettype wire

// ===== bench/id_bitmap_allocator_unit_tb.sv =====
// ----------------------------------------------------------------------------
// id_bitmap_allocator_unit_tb
// Self-checking bench for the bitmap id allocator: a directed table, then
// random allocate/release traffic under several base_id settings and a
// steady tail with no input gaps or output stalls.
// Every result is checked, against the table where a directed row gives one, else against a predictor of the id map.
// ----------------------------------------------------------------------------
module id_bitmap_allocator_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ibma_pkg::*;

  localparam int NUM_IDS     = DEF_NUM_IDS;
  localparam int WORD_BITS   = DEF_WORD_BITS;
  localparam int MAP_WORDS   = (NUM_IDS + WORD_BITS - 1) / WORD_BITS;
  localparam int CYCLE_LIMIT = 3000000;

  typedef struct packed {
    logic [ID_W-1:0] gid;
    status_t         st;
  } grant_t;

  typedef struct packed {
    opcode_t         op;
    logic [ID_W-1:0] rid;
    logic            typed;
    logic [ID_W-1:0] gid;
    status_t         st;
  } dir_row_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   in_tuser   = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_valid  = 1'b0;
  logic                   cfg_ready;
  logic [ID_W-1:0]        cfg_data   = '0;

  // base_id 300 after reset
  dir_row_t directed_rows [20] = '{
    '{OP_ALLOC,   16'h0000, 1'b1, 16'd300,  STAT_OK},
    '{OP_ALLOC,   16'h0000, 1'b1, 16'd301,  STAT_OK},
    '{OP_ALLOC,   16'h0000, 1'b1, 16'd302,  STAT_OK},
    '{OP_RELEASE, 16'd301,  1'b1, 16'd301,  STAT_OK},
    '{OP_RELEASE, 16'd301,  1'b1, 16'd301,  STAT_WAS_FREE},
    '{OP_ALLOC,   16'hFFFF, 1'b1, 16'd301,  STAT_OK},
    '{OP_RELEASE, 16'd299,  1'b1, 16'd299,  STAT_RANGE},
    '{OP_RELEASE, 16'd4396, 1'b1, 16'd4396, STAT_RANGE},
    '{OP_RELEASE, 16'd4395, 1'b1, 16'd4395, STAT_WAS_FREE},
    '{OP_RELEASE, 16'h0000, 1'b1, 16'h0000, STAT_RANGE},
    '{OP_RELEASE, 16'hFFFF, 1'b1, 16'hFFFF, STAT_RANGE},
    '{OP_RELEASE, 16'h8000, 1'b1, 16'h8000, STAT_RANGE},
    '{OP_RELEASE, 16'd332,  1'b1, 16'd332,  STAT_WAS_FREE},
    '{OP_RELEASE, 16'd300,  1'b1, 16'd300,  STAT_OK},
    '{OP_RELEASE, 16'd302,  1'b1, 16'd302,  STAT_OK},
    '{OP_ALLOC,   16'h5555, 1'b1, 16'd300,  STAT_OK},
    '{OP_ALLOC,   16'hAAAA, 1'b1, 16'd302,  STAT_OK},
    '{OP_ALLOC,   16'h0000, 1'b0, 16'd0,    STAT_OK},
    '{OP_RELEASE, 16'd303,  1'b0, 16'd0,    STAT_OK},
    '{OP_RELEASE, 16'd301,  1'b0, 16'd0,    STAT_OK}
  };

  logic [WORD_BITS-1:0] id_map [MAP_WORDS];
  logic [ID_W-1:0]      base_reg;
  int                   ids_in_use;
  grant_t               pending_grants [$];

  int in_gap_pct    = 25;
  int out_stall_pct = 25;
  int mismatch_count;
  int n_alloc_req, n_release_req, n_checked, n_full_seen, n_base_writes;
  int cycles;

  id_bitmap_allocator_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $error("run stalled: %0d results still awaited", pending_grants.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic grant_t predict_grant(opcode_t op, logic [ID_W-1:0] rid);
    grant_t          g;
    logic [ID_W-1:0] idx;
    int              w;
    int              b;
    bit              hit;
    g.gid = '0;
    g.st  = STAT_FULL;
    hit   = 1'b0;
    if (op == OP_ALLOC) begin
      for (w = 0; w < MAP_WORDS && !hit; w++) begin
        if (id_map[w] != '1) begin
          for (b = 0; b < WORD_BITS && !hit; b++) begin
            if (!id_map[w][b]) begin
              id_map[w][b] = 1'b1;
              g.gid = base_reg + ID_W'(w * WORD_BITS + b);
              g.st  = STAT_OK;
              hit   = 1'b1;
              ids_in_use++;
            end
          end
        end
      end
    end else begin
      g.gid = rid;
      idx   = rid - base_reg;
      if (idx >= NUM_IDS) begin
        g.st = STAT_RANGE;
      end else if (id_map[idx / WORD_BITS][idx % WORD_BITS]) begin
        id_map[idx / WORD_BITS][idx % WORD_BITS] = 1'b0;
        g.st = STAT_OK;
        ids_in_use--;
      end else begin
        g.st = STAT_WAS_FREE;
      end
    end
    return g;
  endfunction

  // some id that is currently marked in use, or any in-range id if none
  function automatic logic [ID_W-1:0] pick_held_id();
    int start;
    int k;
    int idx;
    start = $urandom_range(0, NUM_IDS - 1);
    for (k = 0; k < NUM_IDS; k++) begin
      idx = (start + k) % NUM_IDS;
      if (id_map[idx / WORD_BITS][idx % WORD_BITS])
        return base_reg + ID_W'(idx);
    end
    return base_reg + ID_W'(start);
  endfunction

  task automatic issue_request(input opcode_t op, input logic [ID_W-1:0] rid,
                               input bit typed, input grant_t typed_grant);
    grant_t g;
    if (in_gap_pct != 0 && $urandom_range(0, 99) < in_gap_pct) begin
      in_tvalid <= 1'b0;
      in_tdata  <= IN_TDATA_W'($urandom);
      in_tuser  <= 1'($urandom);
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= rid;
    do @(posedge clk); while (!in_tready);
    g = predict_grant(op, rid);
    pending_grants.push_back(typed ? typed_grant : g);
    if (op == OP_ALLOC) n_alloc_req++;
    else n_release_req++;
  endtask

  task automatic random_request();
    int dice;
    dice = $urandom_range(0, 99);
    if (dice < 50)
      issue_request(OP_ALLOC, ID_W'($urandom), 1'b0, '0);
    else if (dice < 80)
      issue_request(OP_RELEASE, pick_held_id(), 1'b0, '0);
    else if (dice < 90)
      issue_request(OP_RELEASE, base_reg + ID_W'($urandom_range(0, NUM_IDS - 1)),
                    1'b0, '0);
    else
      issue_request(OP_RELEASE, ID_W'($urandom), 1'b0, '0);
  endtask

  task automatic write_base_id(input logic [ID_W-1:0] value);
    in_tvalid <= 1'b0;
    while (pending_grants.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    base_reg = value;
    n_base_writes++;
  endtask

  // result side: check each item, stall in random bursts
  initial begin
    grant_t          want;
    logic [ID_W-1:0] got_gid;
    logic [1:0]      got_st;
    int              hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        got_gid = out_tdata[ID_W-1:0];
        got_st  = out_tdata[ID_W+STATUS_W-1:ID_W];
        if (pending_grants.size() == 0) begin
          $error("result with no request waiting: granted_id %0d status %0d",
                 got_gid, got_st);
          mismatch_count++;
        end else begin
          want = pending_grants.pop_front();
          n_checked++;
          if (got_st == STAT_FULL) n_full_seen++;
          if (got_gid !== want.gid) begin
            $error("granted_id: expected %0d, actual %0d", want.gid, got_gid);
            mismatch_count++;
          end
          if (got_st !== want.st) begin
            $error("status: expected %0d, actual %0d", want.st, got_st);
            mismatch_count++;
          end
        end
      end
      if (hold > 0) begin
        hold--;
        out_tready <= 1'b0;
      end else if (out_stall_pct != 0 && $urandom_range(0, 99) < out_stall_pct) begin
        hold = $urandom_range(1, 14) - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin
    int i;
    for (i = 0; i < MAP_WORDS; i++) id_map[i] = '0;
    base_reg   = BASE_ID_RESET;
    ids_in_use = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (i = 0; i < $size(directed_rows); i++)
      issue_request(directed_rows[i].op, directed_rows[i].rid, directed_rows[i].typed,
                    '{gid: directed_rows[i].gid, st: directed_rows[i].st});

    write_base_id(16'd0);
    for (i = 0; i < 300; i++) random_request();

    write_base_id(16'd61439);
    for (i = 0; i < 300; i++) begin
      // a stretch with steady traffic in the middle
      in_gap_pct    = (i >= 120 && i < 220) ? 0 : 25;
      out_stall_pct = (i >= 120 && i < 220) ? 0 : 25;
      random_request();
    end

    write_base_id(ID_W'($urandom_range(0, 61439)));
    for (i = 0; i < 270; i++) random_request();

    in_gap_pct    = 0;
    out_stall_pct = 0;
    for (i = 0; i < 60; i++) random_request();
    in_tvalid <= 1'b0;

    while (pending_grants.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("requests: %0d allocate, %0d release; %0d results checked",
             n_alloc_req, n_release_req, n_checked);
    $display("base_id written %0d times; full map answered %0d times; %0d mismatches",
             n_base_writes, n_full_seen, mismatch_count);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
